// ===== src/scla_pkg.sv =====
// Shared types, sizes and constants of the soft LLR consensus accumulator.
// No dependencies; every other file refers to this package by scoped names.
package scla_pkg;

  localparam int NUM_OLIGOS     = 256;
  localparam int BITS_PER_OLIGO = 512;
  localparam int ENTRIES        = NUM_OLIGOS * BITS_PER_OLIGO;
  localparam int ENT_W          = $clog2(ENTRIES);
  localparam int ROW_W          = (NUM_OLIGOS > 1) ? $clog2(NUM_OLIGOS) : 1;
  localparam int LOG_ITERS      = 20;
  localparam int CFG_IDX_W      = 3;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [23:0] PROB_HALF = 24'h800000;

  localparam logic [1:0] HARD_ZERO  = 2'd0;
  localparam logic [1:0] HARD_ONE   = 2'd1;
  localparam logic [1:0] HARD_ERASE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_MODE    = 3'd0,
    REG_PROB_LIMIT  = 3'd1,
    REG_LLR_SCALE   = 3'd2,
    REG_FINAL_CLIP  = 3'd3,
    REG_READ_CLIP   = 3'd4,
    REG_MAX_READS   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] oligo_pos;
    logic [8:0]  bit_index;
    logic [23:0] prob_one;
    logic        first_of_read;
  } req_t;

  typedef struct packed {
    logic signed [24:0] merged_llr;
    logic [1:0]         hard_bit;
    logic [15:0]        reads_used;
  } rsp_t;

  typedef struct packed {
    logic        cal_mode;
    logic [23:0] prob_limit;
    logic [21:0] llr_scale;
    logic [23:0] final_clip;
    logic [23:0] read_clip;
    logic [15:0] max_reads;
  } cfg_t;

  typedef struct packed {
    logic             is_query;
    logic             first;
    logic             pos_ok;
    logic             bit_ok;
    logic             is_half;
    logic [ROW_W-1:0] row;
    logic [ENT_W-1:0] idx;
    logic [23:0]      prob;
  } job_t;

endpackage

// ===== src/soft_llr_consensus_accumulator.sv =====
// Top level of the soft LLR consensus accumulator: configuration registers,
// front end and back end. Depends on scla_pkg, scla_front and scla_back.
//
// Requests enter through a queue-style port: a request is taken on a clock
// edge with push high and full low. Accumulate requests add one bit posterior
// of one read into the per-oligo, per-bit log-LR sum; query requests return
// one result. Results leave through a queue-style port: the oldest result is
// shown while empty is low and is taken on an edge with pop high.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high. Write them only while the block is idle.
// Sequencing: an informed accumulate waits in ST_LOG for the 20 squaring steps
// of the two log2 units that run side by side; a dropped accumulate returns to
// idle from ST_EXEC, and a query passes ST_EXEC, ST_QMUL and ST_QFIN. Two requests
// may wait in the front queue and two results in the result queue, so the
// sender keeps going while the receiver stalls until both queues fill.
// Reset: synchronous, active high. After reset the back end sweeps the sum
// memory once, clearing sums, informed marks and read counts; requests queue
// up meanwhile and configuration writes are taken as usual.
module soft_llr_consensus_accumulator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  scla_pkg::req_t                      req,
  output logic                                empty,
  input  logic                                pop,
  output scla_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [23:0]                         cfg_data
);

  scla_pkg::cfg_t  cfg;
  scla_pkg::job_t  head;
  logic            head_valid;
  logic            head_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_mode   <= 1'b0;
      cfg.prob_limit <= 24'd905418;
      cfg.llr_scale  <= 22'd32768;
      cfg.final_clip <= 24'd524288;
      cfg.read_clip  <= 24'd262144;
      cfg.max_reads  <= 16'd25;
    end else if (cfg_valid) begin
      case (scla_pkg::cfg_reg_t'(cfg_index))
        scla_pkg::REG_CAL_MODE:   cfg.cal_mode   <= cfg_data[0];
        scla_pkg::REG_PROB_LIMIT: cfg.prob_limit <= cfg_data;
        scla_pkg::REG_LLR_SCALE:  cfg.llr_scale  <= cfg_data[21:0];
        scla_pkg::REG_FINAL_CLIP: cfg.final_clip <= cfg_data;
        scla_pkg::REG_READ_CLIP:  cfg.read_clip  <= cfg_data;
        scla_pkg::REG_MAX_READS:  cfg.max_reads  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  scla_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req        (req),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  scla_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .rsp        (rsp),
    .empty      (empty),
    .pop        (pop)
  );

  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result lost while stalled");

  assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((rsp.hard_bit == scla_pkg::HARD_ERASE) == (rsp.merged_llr == 25'sd0)))
    else $error("erasure does not match zero log-LR");

  assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.hard_bit == scla_pkg::HARD_ONE) |-> !rsp.merged_llr[24])
    else $error("hard one with negative log-LR");

endmodule

// ===== src/scla_front.sv =====
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on scla_pkg.
module scla_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  scla_pkg::req_t    req,
  output scla_pkg::job_t    head,
  output logic              head_valid,
  input  logic              head_pop
);

  scla_pkg::job_t                job_in;
  logic [15:0]                   row_full;
  logic [8:0]                    bit_sel;
  scla_pkg::job_t                q [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    count;
  logic                          do_push;
  logic                          do_pop;

  always_comb begin
    row_full        = req.oligo_pos - 16'd1;
    job_in.is_query = req.req_type;
    job_in.first    = req.first_of_read;
    job_in.pos_ok   = (req.oligo_pos != 16'd0) &&
                      ({16'd0, req.oligo_pos} <= 32'(scla_pkg::NUM_OLIGOS));
    job_in.bit_ok   = {23'd0, req.bit_index} < 32'(scla_pkg::BITS_PER_OLIGO);
    job_in.is_half  = req.prob_one == scla_pkg::PROB_HALF;
    job_in.row      = job_in.pos_ok ? row_full[scla_pkg::ROW_W-1:0] : '0;
    bit_sel         = job_in.bit_ok ? req.bit_index : 9'd0;
    job_in.idx      = scla_pkg::ENT_W'(32'(job_in.row) * 32'(scla_pkg::BITS_PER_OLIGO) +
                                       32'(bit_sel));
    job_in.prob     = req.prob_one;
  end

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= job_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== src/scla_log2.sv =====
// Iterative log2 unit: exponent by priority search, 20 fraction bits by squaring.
// Depends on scla_pkg. Result is unsigned Q.20.
module scla_log2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] a,
  output logic        busy,
  output logic [24:0] result
);

  logic [4:0]  e_in;
  logic [31:0] m_init;
  logic [31:0] m;
  logic [4:0]  e_r;
  logic [19:0] frac;
  logic [4:0]  iter;
  logic [63:0] sq;
  logic [32:0] t;
  logic [31:0] m_next;

  always_comb begin
    e_in = 5'd0;
    for (int i = 1; i < 24; i++) begin
      if (a[i]) e_in = 5'(i);
    end
    m_init = 32'(a) << (5'd31 - e_in);
    sq     = 64'(m) * 64'(m);
    t      = sq[63:31];
    m_next = t[32] ? t[32:1] : t[31:0];
  end

  assign result = {e_r, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= 5'd0;
      m    <= m_init;
      frac <= 20'd0;
      e_r  <= e_in;
    end else if (busy) begin
      m    <= m_next;
      frac <= {frac[18:0], t[32]};
      iter <= iter + 5'd1;
      if (iter == 5'(scla_pkg::LOG_ITERS - 1)) busy <= 1'b0;
    end
  end

endmodule

// ===== src/scla_back.sv =====
// Back end: sequencer over the sum and read-count memories, with a result queue.
// Depends on scla_pkg and scla_log2.
module scla_back (
  input  logic            clk,
  input  logic            rst,
  input  scla_pkg::cfg_t  cfg,
  input  scla_pkg::job_t  head,
  input  logic            head_valid,
  output logic            head_pop,
  output scla_pkg::rsp_t  rsp,
  output logic            empty,
  input  logic            pop
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_LOG, ST_MUL, ST_CLIP, ST_WRITE, ST_QMUL, ST_QFIN
  } state_t;

  state_t                        state;
  scla_pkg::job_t                job;
  logic [32:0]                   sum_mem [scla_pkg::ENTRIES];
  logic [15:0]                   cnt_mem [scla_pkg::NUM_OLIGOS];
  logic [32:0]                   sum_rd;
  logic [15:0]                   cnt_rd;
  logic                          sum_we;
  logic [scla_pkg::ENT_W-1:0]    sum_wa;
  logic [32:0]                   sum_wd;
  logic                          cnt_we;
  logic [scla_pkg::ROW_W-1:0]    cnt_wa;
  logic [15:0]                   cnt_wd;
  logic [scla_pkg::ENT_W-1:0]    clr_addr;
  logic                          clr_row;
  logic                          read_accepted;

  logic                          cap_hit;
  logic                          acc_new;
  logic                          acc_eff;
  logic                          go;
  logic                          cnt_bump;
  logic [23:0]                   p_clamp;
  logic [23:0]                   q_val;
  logic                          log_start;
  logic                          lp_busy;
  logic                          lq_busy;
  logic [24:0]                   lp;
  logic [24:0]                   lq;
  logic [24:0]                   mag;
  logic                          neg;
  logic [56:0]                   prod;
  logic [56:0]                   prod_rnd;
  logic [20:0]                   r_llr;
  logic [23:0]                   r_clip;
  logic signed [31:0]            llr_s;
  logic [32:0]                   s33;
  logic [31:0]                   s_sat;

  logic                          qvalid;
  logic                          qneg;
  logic [31:0]                   qmag;
  logic [32:0]                   qneg_full;
  logic [53:0]                   qprod;
  logic [53:0]                   qprod_rnd;
  logic [37:0]                   qr;
  logic [23:0]                   qr_clip;
  logic [24:0]                   qm25;
  logic [24:0]                   cal_m;
  logic signed [31:0]            s32;
  logic signed [31:0]            lim;
  logic signed [31:0]            prob_m;
  logic [24:0]                   merged;
  scla_pkg::rsp_t                res;

  scla_pkg::rsp_t                oq [2];
  logic                          oq_wr;
  logic                          oq_rd;
  logic [1:0]                    oq_cnt;
  logic                          oq_push;
  logic                          oq_pop;

  assign head_pop  = (state == ST_IDLE) && head_valid && (!head.is_query || oq_cnt != 2'd2);
  assign clr_row   = 32'(clr_addr) < 32'(scla_pkg::NUM_OLIGOS);

  always_comb begin
    cap_hit   = cfg.cal_mode && (cfg.max_reads != 16'd0) && (cnt_rd >= cfg.max_reads);
    acc_new   = job.pos_ok && !cap_hit;
    acc_eff   = job.first ? acc_new : read_accepted;
    go        = acc_eff && job.pos_ok && job.bit_ok && !job.is_half;
    cnt_bump  = (state == ST_EXEC) && !job.is_query && job.first && acc_new &&
                (cnt_rd != 16'hFFFF);
    log_start = (state == ST_EXEC) && !job.is_query && go;
    p_clamp   = (job.prob == 24'd0) ? 24'd1 : job.prob;
    q_val     = 24'(25'h1000000 - {1'b0, p_clamp});

    prod_rnd  = prod + (57'd1 << 35);
    r_llr     = prod_rnd[56:36];
    r_clip    = (cfg.cal_mode && ({3'd0, r_llr} > cfg.read_clip)) ? cfg.read_clip
                                                                  : {3'd0, r_llr};
    s33       = {sum_rd[31], sum_rd[31:0]} + {llr_s[31], llr_s};
    if (s33[32] != s33[31]) begin
      s_sat = s33[32] ? 32'h80000000 : 32'h7FFFFFFF;
    end else begin
      s_sat = s33[31:0];
    end

    qneg_full = 33'd0 - {sum_rd[31], sum_rd[31:0]};
    qprod_rnd = qprod + 54'd32768;
    qr        = qprod_rnd[53:16];
    qr_clip   = (qr > {14'd0, cfg.final_clip}) ? cfg.final_clip : qr[23:0];
    qm25      = {1'b0, qr_clip};
    cal_m     = qneg ? (25'd0 - qm25) : qm25;
    s32       = $signed(sum_rd[31:0]);
    lim       = $signed({8'd0, cfg.prob_limit});
    if (s32 > lim) begin
      prob_m = lim;
    end else if (s32 < -lim) begin
      prob_m = -lim;
    end else begin
      prob_m = s32;
    end
    if (!qvalid) begin
      merged = 25'd0;
    end else if (cfg.cal_mode) begin
      merged = cal_m;
    end else begin
      merged = prob_m[24:0];
    end
    res.merged_llr = $signed(merged);
    if (merged == 25'd0) begin
      res.hard_bit = scla_pkg::HARD_ERASE;
    end else if (merged[24]) begin
      res.hard_bit = scla_pkg::HARD_ZERO;
    end else begin
      res.hard_bit = scla_pkg::HARD_ONE;
    end
    res.reads_used = job.pos_ok ? cnt_rd : 16'd0;

    sum_we = (state == ST_CLEAR) || (state == ST_WRITE);
    sum_wa = (state == ST_CLEAR) ? clr_addr : job.idx;
    sum_wd = (state == ST_CLEAR) ? 33'd0 : {1'b1, s_sat};
    cnt_we = ((state == ST_CLEAR) && clr_row) || cnt_bump;
    cnt_wa = (state == ST_CLEAR) ? clr_addr[scla_pkg::ROW_W-1:0] : job.row;
    cnt_wd = (state == ST_CLEAR) ? 16'd0 : cnt_rd + 16'd1;
  end

  scla_log2 u_log_p (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .a      (p_clamp),
    .busy   (lp_busy),
    .result (lp)
  );

  scla_log2 u_log_q (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .a      (q_val),
    .busy   (lq_busy),
    .result (lq)
  );

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (head_pop) sum_rd <= sum_mem[head.idx];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (head_pop) cnt_rd <= cnt_mem[head.row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      read_accepted <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (32'(clr_addr) == 32'(scla_pkg::ENTRIES - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + scla_pkg::ENT_W'(1);
          end
        end
        ST_IDLE: begin
          if (head_pop) begin
            job   <= head;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (job.is_query) begin
            qvalid <= job.pos_ok && job.bit_ok && sum_rd[32];
            qneg   <= sum_rd[31];
            qmag   <= sum_rd[31] ? qneg_full[31:0] : sum_rd[31:0];
            state  <= ST_QMUL;
          end else begin
            if (job.first) read_accepted <= acc_new;
            state <= go ? ST_LOG : ST_IDLE;
          end
        end
        ST_LOG: begin
          if (!lp_busy && !lq_busy) begin
            neg   <= lp < lq;
            mag   <= (lp < lq) ? lq - lp : lp - lq;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= 57'(mag) * 57'(scla_pkg::LN2_Q32);
          state <= ST_CLIP;
        end
        ST_CLIP: begin
          llr_s <= neg ? -$signed({8'd0, r_clip}) : $signed({8'd0, r_clip});
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          state <= ST_IDLE;
        end
        ST_QMUL: begin
          qprod <= 54'(qmag) * 54'(cfg.llr_scale);
          state <= ST_QFIN;
        end
        ST_QFIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign oq_push = state == ST_QFIN;
  assign oq_pop  = pop && !empty;
  assign empty   = oq_cnt == 2'd0;
  assign rsp     = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (oq_push) oq[oq_wr] <= res;
    if (rst) begin
      oq_wr  <= 1'b0;
      oq_rd  <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      if (oq_push) oq_wr <= !oq_wr;
      if (oq_pop) oq_rd <= !oq_rd;
      oq_cnt <= oq_cnt + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

endmodule
